// ===== design/brfd_pkg.sv =====
package brfd_pkg;

    localparam int DEPTH_DEFAULT    = 1024;
    localparam int MAX_READ_DEFAULT = 64;

    localparam int SIZE_W     = 11;
    localparam int BYTE_W     = 8;
    localparam int BCOUNT_W   = 10;
    localparam int REQ_W      = 7;
    localparam int FILL_OUT_W = 10;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 4;

    localparam logic [1:0] CMD_WRITE      = 2'd0;
    localparam logic [1:0] CMD_READ_COUNT = 2'd1;
    localparam logic [1:0] CMD_READ_DELIM = 2'd2;
    localparam logic [1:0] CMD_NONE       = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_REJECTED = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept_single;
        logic start_read;
        logic emit_byte;
    } brfd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] in_command;
        logic       req_zero;
        logic       fill_zero;
        logic       out_free;
        logic       read_last;
    } brfd_status_t;

endpackage

// ===== design/brfd_ctrl.sv =====
module brfd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  brfd_pkg::brfd_status_t dp_status,
    output brfd_pkg::brfd_cmd_t    ctrl_cmd
);
    import brfd_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_SEND  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       is_read;

    assign is_read = dp_status.in_command inside {CMD_READ_COUNT, CMD_READ_DELIM};

    always_comb begin
        ctrl_cmd   = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                s_tready = dp_status.out_free;
                if (s_tvalid && dp_status.out_free) begin
                    // Only a read that will return bytes needs the byte loop.
                    if (is_read && !dp_status.fill_zero && !dp_status.req_zero) begin
                        ctrl_cmd.start_read = 1'b1;
                        state_next          = S_FETCH;
                    end else begin
                        ctrl_cmd.accept_single = 1'b1;
                    end
                end
            end
            S_FETCH: begin
                state_next = S_SEND;
            end
            S_SEND: begin
                if (dp_status.out_free) begin
                    ctrl_cmd.emit_byte = 1'b1;
                    state_next = dp_status.read_last ? S_IDLE : S_FETCH;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/brfd_datapath.sv =====
module brfd_datapath #(
    parameter int DEPTH    = brfd_pkg::DEPTH_DEFAULT,
    parameter int MAX_READ = brfd_pkg::MAX_READ_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [brfd_pkg::SIZE_W-1:0]     cfg_data,
    input  logic [brfd_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [brfd_pkg::S_TUSER_W-1:0]  s_tuser,
    input  brfd_pkg::brfd_cmd_t             ctrl_cmd,
    output brfd_pkg::brfd_status_t          dp_status,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [brfd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [brfd_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                            m_tlast
);
    import brfd_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = ((PW > SIZE_W) ? PW : SIZE_W) + 1;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'((DEPTH < 1024) ? DEPTH : 1024);
    localparam logic [REQ_W-1:0]  REQ_MAX    = REQ_W'(MAX_READ);

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p,
                                           input logic [SIZE_W-1:0] sz);
        logic [CW-1:0] nx;
        nx = CW'(p) + CW'(1);
        return (nx >= CW'(sz)) ? '0 : PW'(nx);
    endfunction

    // Input item fields.
    logic [1:0]          in_command;
    logic                in_first;
    logic [BYTE_W-1:0]   in_wbyte;
    logic [BCOUNT_W-1:0] in_bcount;
    logic [REQ_W-1:0]    in_req;
    logic [BYTE_W-1:0]   in_delim;

    assign in_command = s_tuser[1:0];
    assign in_first   = s_tuser[2];
    assign in_wbyte   = s_tdata[7:0];
    assign in_bcount  = s_tdata[17:8];
    assign in_req     = s_tdata[24:18];
    assign in_delim   = s_tdata[32:25];

    logic [SIZE_W-1:0]   size_reg;
    logic [PW-1:0]       rp_reg;
    logic [PW-1:0]       wp_reg;
    logic [SIZE_W-1:0]   fill_reg;
    logic                rej_reg;
    logic [BCOUNT_W-1:0] left_reg;

    logic                is_delim_reg;
    logic [BYTE_W-1:0]   delim_reg;
    logic [REQ_W-1:0]    rd_left_reg;
    logic [REQ_W-1:0]    done_reg;

    logic [BYTE_W-1:0]   mem [DEPTH];
    logic [BYTE_W-1:0]   mem_q;

    logic                m_valid_reg;
    logic                m_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                out_bvalid_reg;
    logic [1:0]          out_status_reg;
    logic [REQ_W-1:0]    out_done_reg;
    logic                out_found_reg;
    logic                out_last_reg;
    logic [FILL_OUT_W-1:0] out_fill_reg;

    logic [SIZE_W-1:0]   cfg_sat;
    logic [REQ_W-1:0]    req_sat;
    logic [SIZE_W-1:0]   free_space;
    logic [BCOUNT_W-1:0] bc_eff;
    logic                bc_too_big;
    logic                burst_rej_w;
    logic [BCOUNT_W-1:0] burst_left_w;
    logic                do_write;
    logic                store;
    logic [REQ_W-1:0]    read_n;
    logic                found;
    logic                read_last;
    logic [1:0]          single_status;
    logic [SIZE_W-1:0]   fill_inc;
    logic [SIZE_W-1:0]   fill_dec;

    always_comb begin
        if (cfg_data < SIZE_W'(2)) begin
            cfg_sat = SIZE_W'(2);
        end else if (int'(cfg_data) > DEPTH) begin
            cfg_sat = SIZE_W'(DEPTH);
        end else begin
            cfg_sat = cfg_data;
        end
    end

    assign req_sat    = (in_req > REQ_MAX) ? REQ_MAX : in_req;
    // One slot always stays free so that a full buffer never looks empty.
    assign free_space = size_reg - SIZE_W'(1) - fill_reg;
    assign bc_eff     = (in_bcount == '0) ? BCOUNT_W'(1) : in_bcount;
    assign bc_too_big = {1'b0, bc_eff} > free_space;

    assign burst_rej_w  = in_first ? bc_too_big : rej_reg;
    assign burst_left_w = in_first ? (bc_too_big ? '0 : bc_eff) : left_reg;
    assign do_write     = ctrl_cmd.accept_single && (in_command == CMD_WRITE);
    assign store        = do_write && !burst_rej_w && (burst_left_w != '0);

    assign fill_inc = fill_reg + SIZE_W'(1);
    assign fill_dec = fill_reg - SIZE_W'(1);

    assign read_n    = ({{(SIZE_W-REQ_W){1'b0}}, req_sat} < fill_reg) ? req_sat
                                                                      : fill_reg[REQ_W-1:0];
    assign found     = is_delim_reg && (mem_q == delim_reg);
    assign read_last = found || (rd_left_reg == REQ_W'(1));

    always_comb begin
        case (in_command)
            CMD_WRITE: single_status = store ? STAT_OK : STAT_REJECTED;
            CMD_NONE:  single_status = STAT_OK;
            default:   single_status = (fill_reg == '0) ? STAT_EMPTY : STAT_OK;
        endcase
    end

    assign m_valid_next = (ctrl_cmd.accept_single || ctrl_cmd.emit_byte) ? 1'b1
                        : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg    <= SIZE_RESET;
            rp_reg      <= '0;
            wp_reg      <= '0;
            fill_reg    <= '0;
            rej_reg     <= 1'b0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                size_reg <= cfg_sat;
                rp_reg   <= '0;
                wp_reg   <= '0;
                fill_reg <= '0;
                rej_reg  <= 1'b0;
                left_reg <= '0;
            end else begin
                if (do_write) begin
                    rej_reg  <= burst_rej_w;
                    left_reg <= store ? burst_left_w - BCOUNT_W'(1) : burst_left_w;
                    if (store) begin
                        wp_reg   <= bump(wp_reg, size_reg);
                        fill_reg <= fill_inc;
                    end
                end
                if (ctrl_cmd.emit_byte) begin
                    rp_reg   <= bump(rp_reg, size_reg);
                    fill_reg <= fill_dec;
                end
            end
        end
    end

    // The read port follows the read pointer; its data is registered and valid in the cycle after the pointer settles.
    always_ff @(posedge aclk) begin
        if (store) begin
            mem[wp_reg] <= in_wbyte;
        end
        mem_q <= mem[rp_reg];
    end

    always_ff @(posedge aclk) begin
        if (ctrl_cmd.start_read) begin
            delim_reg    <= in_delim;
            is_delim_reg <= (in_command == CMD_READ_DELIM);
            rd_left_reg  <= read_n;
            done_reg     <= '0;
        end else if (ctrl_cmd.emit_byte) begin
            rd_left_reg <= rd_left_reg - REQ_W'(1);
            done_reg    <= done_reg + REQ_W'(1);
        end
        if (ctrl_cmd.accept_single) begin
            out_byte_reg   <= '0;
            out_bvalid_reg <= 1'b0;
            out_status_reg <= single_status;
            out_done_reg   <= '0;
            out_found_reg  <= 1'b0;
            out_last_reg   <= 1'b1;
            out_fill_reg   <= store ? fill_inc[FILL_OUT_W-1:0] : fill_reg[FILL_OUT_W-1:0];
        end else if (ctrl_cmd.emit_byte) begin
            out_byte_reg   <= mem_q;
            out_bvalid_reg <= 1'b1;
            out_status_reg <= STAT_OK;
            out_done_reg   <= done_reg + REQ_W'(1);
            out_found_reg  <= found;
            out_last_reg   <= read_last;
            out_fill_reg   <= fill_dec[FILL_OUT_W-1:0];
        end
    end

    assign dp_status.in_command = in_command;
    assign dp_status.req_zero   = (in_req == '0);
    assign dp_status.fill_zero  = (fill_reg == '0);
    assign dp_status.out_free   = !m_valid_reg || m_tready;
    assign dp_status.read_last  = read_last;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-25){1'b0}}, out_fill_reg, out_done_reg, out_byte_reg};
    assign m_tuser  = {out_found_reg, out_status_reg, out_bvalid_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== design/byte_ring_fifo_with_delimiter_read_unit.sv =====
// Circular byte FIFO with whole-burst write admission and counted or
// delimiter-terminated reads.
// Input channel s_*: one command item per handshake. Write items store one
// byte of a burst; the first byte of a burst carries its length, and the
// whole burst is refused if it does not fit the free space (size - 1 - fill).
// Read items return up to request_count bytes, one result item each; a
// delimiter read also ends on the matching byte, which is included.
// Result channel m_*: m_tlast marks the final result of an input item.
// Configuration channel cfg_*: writes the buffer size in use and empties
// the FIFO; it is always ready.
// Timing: write, empty-read and other single-result items are accepted one
// per cycle while the output is free, and their result appears in the output
// register the cycle after. A read that returns bytes fetches each byte
// through the registered read port of the byte store before sending it, and
// the next item is taken after its last byte has been loaded.
// Reset empties the FIFO and sets the size in use to 1024 (or DEPTH if
// smaller). When the receiver stalls, the result holds in the output
// register and new input items are held off until it is taken.
module byte_ring_fifo_with_delimiter_read_unit #(
    parameter int DEPTH    = brfd_pkg::DEPTH_DEFAULT,
    parameter int MAX_READ = brfd_pkg::MAX_READ_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [brfd_pkg::SIZE_W-1:0]     cfg_data,   // size_in_use
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // write_byte, burst_count, request_count, delimiter, zero pad
    input  logic [brfd_pkg::S_TDATA_W-1:0]  s_tdata,
    // command, burst_first
    input  logic [brfd_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_byte, count_done, fill_level, zero pad
    output logic [brfd_pkg::M_TDATA_W-1:0]  m_tdata,
    // byte_valid, status, found_delimiter
    output logic [brfd_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                            m_tlast
);
    import brfd_pkg::*;

    brfd_cmd_t    ctrl_cmd;
    brfd_status_t dp_status;

    assign cfg_ready = 1'b1;

    brfd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .ctrl_cmd  (ctrl_cmd)
    );

    brfd_datapath #(
        .DEPTH    (DEPTH),
        .MAX_READ (MAX_READ)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .ctrl_cmd  (ctrl_cmd),
        .dp_status (dp_status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== design/brfd_checker.sv =====
module brfd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [brfd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [brfd_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                           m_tlast
);
    import brfd_pkg::*;

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // A result without a byte is a status result and always ends its item.
    a_nobyte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[14:0] == 15'd0) && !m_tuser[3])
        else $error("status result is malformed");

    // A delimiter match ends the read.
    a_delim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> m_tlast && m_tuser[0])
        else $error("delimiter byte did not end the read");

    // Bytes only come with an ok status and a nonzero count.
    a_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tuser[2:1] == STAT_OK) && (m_tdata[14:8] != 7'd0))
        else $error("byte result with bad status or count");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind byte_ring_fifo_with_delimiter_read_unit brfd_checker u_brfd_checker (.*);
